### rtl/core/pdsq_pkg.sv
`timescale 1ns / 1ps
package pdsq_pkg;

    localparam int DEPTH_W = 32;
    localparam int SLOT_W  = 6;
    localparam int KIND_W  = 2;

    // input selector
    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REJECT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SORTED = 2'd2;
    localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd3;

    // one entry held by a sort cell
    typedef struct packed {
        logic                      valid;
        logic [SLOT_W-1:0]         slot;
        logic signed [DEPTH_W-1:0] depth;
    } entry_t;

    // broadcast control for the cell chain
    typedef struct packed {
        logic insert;
        logic drain;
        logic ascending;
    } chain_ctrl_t;

endpackage

### rtl/core/primitive_depth_sort_queue.sv
`timescale 1ns / 1ps
// Push: sum, load, five byte-wide divide steps in pdsq_avg, store, output register,
//   in that order from accepted word to result; one item in flight at a time.
// Rejected push and empty flush: the response is registered, then moved to the output register.
// Flush of n entries: the depth RAM is streamed into the cell chain (one read
//   port, one insert per cycle), then n results at one per cycle when the sink is ready.
// rst_n (async, active low) empties the queue and the chain; sort order resets to farthest first.
module primitive_depth_sort_queue
    import pdsq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic         clk,
    input  logic         rst_n,

    input  logic         cfg_wr_en,
    input  logic         cfg_wr_data,        // sort_ascending

    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,       // depth_a, depth_b, depth_c, depth_d
    input  logic [2:0]   s_axis_tuser,       // command, prim_type

    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [39:0]  m_axis_tdata,       // slot_index, average_depth, zero pad
    output logic [1:0]   m_axis_tuser,       // result_kind
    output logic         m_axis_tlast        // last_of_run
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {ST_IDLE, ST_DIV, ST_RESP, ST_FILL, ST_DRAIN} state_t;

    // ---------------------------------------------------------------------
    // State
    // ---------------------------------------------------------------------
    state_t                    state_reg;
    logic [CNT_W-1:0]          count_reg;      // stored slots
    logic                      ascending_reg;
    logic [KIND_W-1:0]         resp_kind_reg;  // single-word response waiting
    logic [SLOT_W-1:0]         resp_slot_reg;
    logic signed [DEPTH_W-1:0] resp_avg_reg;
    logic [CNT_W-1:0]          rd_idx_reg;     // RAM reads issued during fill
    logic                      ins_valid_reg;  // RAM data valid this cycle
    logic [SLOT_W-1:0]         ins_slot_reg;
    logic [CNT_W-1:0]          drain_left_reg;

    // output register: parts the sink from the FSM
    logic                      out_valid_reg;
    logic [KIND_W-1:0]         out_kind_reg;
    logic [SLOT_W-1:0]         out_slot_reg;
    logic signed [DEPTH_W-1:0] out_avg_reg;
    logic                      out_last_reg;

    logic                      in_accept;
    logic                      in_cmd;
    logic [1:0]                in_type;
    logic                      out_free;
    logic                      queue_full;
    logic                      fill_issue;

    logic                      div_start;
    logic                      div_done;
    logic signed [DEPTH_W-1:0] div_avg;

    logic                      ram_we;
    logic [DEPTH_W-1:0]        ram_rdata;

    chain_ctrl_t               chain_ctrl;
    entry_t                    new_entry;
    entry_t                    chain_q    [QUEUE_DEPTH];
    logic                      chain_goes [QUEUE_DEPTH];

    // ---------------------------------------------------------------------
    // Handshake decode
    // ---------------------------------------------------------------------
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_cmd        = s_axis_tuser[0];
    assign in_type       = s_axis_tuser[2:1];
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign queue_full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign fill_issue    = (rd_idx_reg != count_reg);

    // ---------------------------------------------------------------------
    // Averaging unit: sum of used vertices divided by vertex count
    // ---------------------------------------------------------------------
    assign div_start = in_accept && (in_cmd == CMD_PUSH) && !queue_full;

    pdsq_avg u_avg (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .prim_type (in_type),
        .depth_a   (s_axis_tdata[31:0]),
        .depth_b   (s_axis_tdata[63:32]),
        .depth_c   (s_axis_tdata[95:64]),
        .depth_d   (s_axis_tdata[127:96]),
        .done      (div_done),
        .average   (div_avg)
    );

    // ---------------------------------------------------------------------
    // Depth store, written in push order, read back in slot order on flush
    // ---------------------------------------------------------------------
    assign ram_we = (state_reg == ST_DIV) && div_done;

    pdsq_ram #(
        .WIDTH (DEPTH_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_depth_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (div_avg),
        .raddr (rd_idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------------
    // Sort chain: cell 0 is the head. Each insert lands after every entry of
    // equal depth; drain shifts the chain one place towards the head.
    // ---------------------------------------------------------------------
    assign chain_ctrl.insert    = (state_reg == ST_FILL) && ins_valid_reg;
    assign chain_ctrl.drain     = (state_reg == ST_DRAIN) && out_free;
    assign chain_ctrl.ascending = ascending_reg;

    assign new_entry.valid = 1'b1;
    assign new_entry.slot  = ins_slot_reg;
    assign new_entry.depth = ram_rdata;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        entry_t prev_e;
        entry_t next_e;
        logic   prev_g;

        if (i == 0)
        begin : g_head
            assign prev_e = '0;
            assign prev_g = 1'b0;
        end
        else
        begin : g_body
            assign prev_e = chain_q[i-1];
            assign prev_g = chain_goes[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign next_e = '0;
        end
        else
        begin : g_link
            assign next_e = chain_q[i+1];
        end

        pdsq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (chain_ctrl),
            .new_entry  (new_entry),
            .prev_entry (prev_e),
            .prev_goes  (prev_g),
            .next_entry (next_e),
            .entry      (chain_q[i]),
            .goes       (chain_goes[i])
        );
    end

    // ---------------------------------------------------------------------
    // Sort order register
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ascending_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            ascending_reg <= cfg_wr_data;
        end
    end

    // ---------------------------------------------------------------------
    // Control FSM and output register
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            rd_idx_reg     <= '0;
            ins_valid_reg  <= 1'b0;
            drain_left_reg <= '0;
            out_valid_reg  <= 1'b0;
            resp_kind_reg  <= KIND_ACCEPT;
            resp_slot_reg  <= '0;
            resp_avg_reg   <= '0;
            ins_slot_reg   <= '0;
            out_kind_reg   <= KIND_ACCEPT;
            out_slot_reg   <= '0;
            out_avg_reg    <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        if (in_cmd == CMD_PUSH)
                        begin
                            if (queue_full)
                            begin
                                resp_kind_reg <= KIND_REJECT;
                                resp_slot_reg <= '0;
                                resp_avg_reg  <= '0;
                                state_reg     <= ST_RESP;
                            end
                            else
                            begin
                                state_reg <= ST_DIV;
                            end
                        end
                        else if (count_reg == '0)
                        begin
                            resp_kind_reg <= KIND_EMPTY;
                            resp_slot_reg <= '0;
                            resp_avg_reg  <= '0;
                            state_reg     <= ST_RESP;
                        end
                        else
                        begin
                            rd_idx_reg    <= '0;
                            ins_valid_reg <= 1'b0;
                            state_reg     <= ST_FILL;
                        end
                    end
                end

                ST_DIV:
                begin
                    if (div_done)
                    begin
                        resp_kind_reg <= KIND_ACCEPT;
                        resp_slot_reg <= SLOT_W'(count_reg);
                        resp_avg_reg  <= div_avg;
                        count_reg     <= count_reg + CNT_W'(1);
                        state_reg     <= ST_RESP;
                    end
                end

                ST_RESP:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_kind_reg  <= resp_kind_reg;
                        out_slot_reg  <= resp_slot_reg;
                        out_avg_reg   <= resp_avg_reg;
                        out_last_reg  <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end

                ST_FILL:
                begin
                    // read slot k while slot k-1 is inserted
                    if (fill_issue)
                    begin
                        rd_idx_reg    <= rd_idx_reg + CNT_W'(1);
                        ins_slot_reg  <= SLOT_W'(rd_idx_reg);
                        ins_valid_reg <= 1'b1;
                    end
                    else
                    begin
                        ins_valid_reg  <= 1'b0;
                        drain_left_reg <= count_reg;
                        count_reg      <= '0;
                        state_reg      <= ST_DRAIN;
                    end
                end

                ST_DRAIN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_kind_reg   <= KIND_SORTED;
                        out_slot_reg   <= chain_q[0].slot;
                        out_avg_reg    <= chain_q[0].depth;
                        out_last_reg   <= (drain_left_reg == CNT_W'(1));
                        drain_left_reg <= drain_left_reg - CNT_W'(1);
                        if (drain_left_reg == CNT_W'(1))
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_avg_reg, out_slot_reg};
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

    // ---------------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("average finished outside a push");

    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DRAIN |-> chain_q[0].valid)
        else $error("drain reached an empty cell");

    a_chain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !chain_q[0].valid)
        else $error("chain not empty between flushes");

endmodule

### rtl/core/pdsq_ram.sv
`timescale 1ns / 1ps
module pdsq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/pdsq_avg.sv
`timescale 1ns / 1ps
module pdsq_avg
    import pdsq_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [1:0]                prim_type,
    input  logic signed [DEPTH_W-1:0] depth_a,
    input  logic signed [DEPTH_W-1:0] depth_b,
    input  logic signed [DEPTH_W-1:0] depth_c,
    input  logic signed [DEPTH_W-1:0] depth_d,
    output logic                      done,
    output logic signed [DEPTH_W-1:0] average
);

    localparam int SUM_W  = DEPTH_W + 2;
    localparam int DVD_W  = 40;          // sum magnitude padded to whole bytes
    localparam int ITERS  = DVD_W / 8;

    typedef enum logic [1:0] {DV_IDLE, DV_LOAD, DV_RUN} dv_state_t;

    dv_state_t                 state_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic [DVD_W-1:0]          dvd_reg;
    logic [DVD_W-1:0]          quo_reg;
    logic [2:0]                rem_reg;
    logic [2:0]                div_reg;
    logic [2:0]                iter_reg;
    logic                      neg_reg;
    logic                      done_reg;

    logic signed [SUM_W-1:0]   sum_next;
    logic [SUM_W-1:0]          mag;
    logic [7:0]                q8;
    logic [2:0]                rem_next;

    // unused vertices contribute nothing
    always_comb
    begin
        sum_next = SUM_W'(depth_a);
        if (prim_type >= 2'd1)
        begin
            sum_next = sum_next + SUM_W'(depth_b);
        end
        if (prim_type >= 2'd2)
        begin
            sum_next = sum_next + SUM_W'(depth_c);
        end
        if (prim_type >= 2'd3)
        begin
            sum_next = sum_next + SUM_W'(depth_d);
        end
    end

    assign mag = sum_reg[SUM_W-1] ? (~sum_reg + SUM_W'(1)) : sum_reg;

    // eight restoring steps per cycle, MSB first
    always_comb
    begin
        logic [3:0] t;
        logic [2:0] r;
        r  = rem_reg;
        q8 = '0;
        for (int k = 7; k >= 0; k--)
        begin
            t = {r, dvd_reg[DVD_W-8+k]};
            if (t >= {1'b0, div_reg})
            begin
                t     = t - {1'b0, div_reg};
                q8[k] = 1'b1;
            end
            r = t[2:0];
        end
        rem_next = r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            iter_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                DV_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= DV_LOAD;
                    end
                end
                DV_LOAD:
                begin
                    iter_reg  <= '0;
                    state_reg <= DV_RUN;
                end
                DV_RUN:
                begin
                    iter_reg <= iter_reg + 3'd1;
                    if (iter_reg == 3'(ITERS - 1))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= DV_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= DV_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            DV_IDLE:
            begin
                if (start)
                begin
                    sum_reg <= sum_next;
                    div_reg <= 3'(prim_type) + 3'd1;
                end
            end
            DV_LOAD:
            begin
                dvd_reg <= {{(DVD_W-SUM_W){1'b0}}, mag};
                neg_reg <= sum_reg[SUM_W-1];
                rem_reg <= '0;
                quo_reg <= '0;
            end
            DV_RUN:
            begin
                dvd_reg <= {dvd_reg[DVD_W-9:0], 8'h00};
                quo_reg <= {quo_reg[DVD_W-9:0], q8};
                rem_reg <= rem_next;
            end
            default:
            begin
                rem_reg <= rem_reg;
            end
        endcase
    end

    // truncation toward zero: divide the magnitude, then restore the sign
    assign done    = done_reg;
    assign average = neg_reg ? -quo_reg[DEPTH_W-1:0] : quo_reg[DEPTH_W-1:0];

endmodule

### rtl/core/pdsq_cell.sv
`timescale 1ns / 1ps
module pdsq_cell
    import pdsq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  chain_ctrl_t ctrl,
    input  entry_t      new_entry,
    input  entry_t      prev_entry,
    input  logic        prev_goes,
    input  entry_t      next_entry,
    output entry_t      entry,
    output logic        goes
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   ahead;

    // strict compare keeps equal depths in arrival order
    assign ahead = ctrl.ascending ? (new_entry.depth < entry_reg.depth)
                                  : (new_entry.depth > entry_reg.depth);
    assign goes  = !entry_reg.valid || ahead;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.drain)
        begin
            entry_next = next_entry;
        end
        else if (ctrl.insert && goes)
        begin
            entry_next = prev_goes ? prev_entry : new_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

### tb/primitive_depth_sort_queue_tb.sv
`timescale 1ns / 1ps
module primitive_depth_sort_queue_tb;
    import pdsq_pkg::*;

    localparam int QUEUE_DEPTH   = 64;
    localparam int RANDOM_ITEMS  = 150;
    // cycles with no word moving on either side before the run is abandoned;
    // a full flush loads the whole chain, then sends 64 words against a slow sink
    localparam int STALL_LIMIT   = 4000;
    // extra cycles at the end to settle anything left
    localparam int DRAIN_CYCLES  = 40;

    // one input word: depth[0] is depth_a, in the low bits of tdata
    typedef struct packed {
        logic                     cmd;
        logic [1:0]               ptype;
        logic [3:0][DEPTH_W-1:0]  depth;
    } prim_word_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [SLOT_W-1:0]  slot;
        logic [DEPTH_W-1:0] avg;
        logic               last;
    } result_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic         cfg_wr_data = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_ready = 1'b0;
    logic [39:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;

    // stimulus waiting to be sent, and results owed by the block
    prim_word_t prims_to_send[$];
    result_t    results_due[$];

    // predictor's copy of the block state
    logic                      nearest_first = 1'b0;
    logic signed [DEPTH_W-1:0] slot_avg [QUEUE_DEPTH];
    int                        slots_held = 0;

    int mismatches   = 0;
    int pushes_taken = 0;
    int pushes_full  = 0;
    int flushes      = 0;
    int empty_flush  = 0;
    int sorted_words = 0;
    int words_seen   = 0;
    int order_writes = 0;

    int burst_left = 0;
    int gap_left   = 0;
    int ready_mode = 0;
    int mode_left  = 0;
    int quiet_cycles = 0;

    primitive_depth_sort_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // --------------------------------------------------------------------
    // Predictor: works out the words owed for one accepted input word.
    // Push: exact wide sum of the used vertices, divided by the vertex count
    // with truncation toward zero, or a reject on a full queue. Flush: stable
    // order by average, nearest or farthest first as the order bit says.
    // --------------------------------------------------------------------
    function automatic logic goes_first(input logic signed [DEPTH_W-1:0] x,
                                        input logic signed [DEPTH_W-1:0] y);
        return nearest_first ? (x < y) : (x > y);
    endfunction

    task automatic compute_depth_results(input prim_word_t w);
        longint  acc;
        longint  quot;
        int      order[$];
        int      at;
        result_t r;
        if (w.cmd == CMD_PUSH)
        begin
            if (slots_held >= QUEUE_DEPTH)
            begin
                r = '{kind: KIND_REJECT, slot: '0, avg: '0, last: 1'b1};
                pushes_full++;
            end
            else
            begin
                acc = 0;
                for (int v = 0; v <= int'(w.ptype); v++)
                    acc += longint'(signed'(w.depth[v]));
                quot = acc / (longint'(w.ptype) + 1);
                slot_avg[slots_held] = quot[DEPTH_W-1:0];
                r = '{kind: KIND_ACCEPT, slot: SLOT_W'(slots_held),
                      avg: quot[DEPTH_W-1:0], last: 1'b1};
                slots_held++;
                pushes_taken++;
            end
            results_due.push_back(r);
        end
        else
        begin
            flushes++;
            if (slots_held == 0)
            begin
                r = '{kind: KIND_EMPTY, slot: '0, avg: '0, last: 1'b1};
                results_due.push_back(r);
                empty_flush++;
            end
            else
            begin
                // insert each slot after every earlier slot it does not beat
                for (int s = 0; s < slots_held; s++)
                begin
                    at = order.size();
                    while (at > 0 && goes_first(slot_avg[s], slot_avg[order[at-1]]))
                        at--;
                    order.insert(at, s);
                end
                foreach (order[k])
                begin
                    r = '{kind: KIND_SORTED, slot: SLOT_W'(order[k]),
                          avg: slot_avg[order[k]], last: (k == order.size() - 1)};
                    results_due.push_back(r);
                end
                sorted_words += slots_held;
                slots_held = 0;
            end
        end
    endtask

    // --------------------------------------------------------------------
    // Sender: bursts of random length with random gaps, fed from
    // prims_to_send. A word stays on the bus until taken.
    // --------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic taken;
        logic present;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            taken = s_tvalid && s_axis_tready;
            if (taken)
                compute_depth_results(prims_to_send.pop_front());
            present = s_tvalid && !taken;
            if (!present && prims_to_send.size() != 0)
            begin
                if (gap_left != 0)
                    gap_left--;
                else
                begin
                    present = 1'b1;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        // some bursts run straight into the next one
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end
                    else
                        burst_left--;
                end
            end
            s_tvalid <= present;
            if (present)
            begin
                s_tdata <= prims_to_send[0].depth;
                s_tuser <= {prims_to_send[0].ptype, prims_to_send[0].cmd};
            end
        end
    end

    // --------------------------------------------------------------------
    // Receiver: compares each word taken with the oldest one owed, and
    // stalls in modes of its own (always ready, half ready, rarely ready).
    // --------------------------------------------------------------------
    task automatic check_field(input string what, input logic [DEPTH_W-1:0] want,
                               input logic [DEPTH_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        logic    ready_next;
        if (!rst_n)
            m_ready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_ready)
            begin
                words_seen++;
                if (results_due.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none actual kind %0h slot %0h",
                             $time, m_axis_tuser, m_axis_tdata[5:0]);
                    mismatches++;
                end
                else
                begin
                    want = results_due.pop_front();
                    check_field("result_kind", want.kind, m_axis_tuser);
                    check_field("slot_index", want.slot, m_axis_tdata[5:0]);
                    check_field("average_depth", want.avg, m_axis_tdata[37:6]);
                    check_field("last_of_run", want.last, m_axis_tlast);
                end
            end
            if (mode_left == 0)
            begin
                ready_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(20, 200);
            end
            else
                mode_left--;
            case (ready_mode)
                0:       ready_next = 1'b1;
                1:       ready_next = $urandom_range(0, 1);
                default: ready_next = ($urandom_range(0, 4) == 0);
            endcase
            m_ready <= ready_next;
        end
    end

    // watchdog: ends the run if no word moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_ready) || cfg_wr_en)
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
                $display("primitive_depth_sort_queue_tb failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // --------------------------------------------------------------------
    // Stimulus
    // --------------------------------------------------------------------
    task automatic add_word(input logic cmd, input logic [1:0] ptype,
                            input logic [DEPTH_W-1:0] a, input logic [DEPTH_W-1:0] b,
                            input logic [DEPTH_W-1:0] c, input logic [DEPTH_W-1:0] d);
        prim_word_t w;
        w.cmd   = cmd;
        w.ptype = ptype;
        w.depth = {d, c, b, a};
        prims_to_send.push_back(w);
    endtask

    // full-range values half the time, with extremes and small repeats for ties
    function automatic logic [DEPTH_W-1:0] pick_depth();
        case ($urandom_range(0, 7))
            0:       return {1'b0, {(DEPTH_W-1){1'b1}}};
            1:       return {1'b1, {(DEPTH_W-1){1'b0}}};
            2, 3:    return DEPTH_W'($signed($urandom_range(0, 6)) - 3) << 16;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_random_push();
        add_word(CMD_PUSH, 2'($urandom_range(0, 3)),
                 pick_depth(), pick_depth(), pick_depth(), pick_depth());
    endtask

    // flush fields are don't-care, so they carry junk
    task automatic add_flush();
        add_word(CMD_FLUSH, 2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (prims_to_send.size() != 0 || results_due.size() != 0)
            @(negedge clk);
    endtask

    // order bit changes only with the block idle
    task automatic set_order(input logic asc);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= asc;
        nearest_first = asc;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        order_writes++;
        @(negedge clk);
    endtask

    initial
    begin
        localparam logic [DEPTH_W-1:0] D_MAX = {1'b0, {(DEPTH_W-1){1'b1}}};
        localparam logic [DEPTH_W-1:0] D_MIN = {1'b1, {(DEPTH_W-1){1'b0}}};
        localparam logic [DEPTH_W-1:0] D_M1  = '1;
        int random_items;
        int group;
        int n;
        random_items = 0;
        group        = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: farthest first from reset
        add_flush();                                            // empty queue
        add_word(CMD_PUSH, 2'd0, D_MAX, $urandom, $urandom, $urandom);
        add_word(CMD_PUSH, 2'd0, D_MIN, $urandom, $urandom, $urandom);
        add_word(CMD_PUSH, 2'd1, D_MAX, D_MAX, $urandom, $urandom);
        add_word(CMD_PUSH, 2'd1, D_MIN, D_MIN, $urandom, $urandom);
        add_word(CMD_PUSH, 2'd2, D_M1, D_M1, 32'd0, $urandom);  // -2/3 rounds to zero
        add_word(CMD_PUSH, 2'd2, 32'd1, 32'd1, 32'd0, $urandom);
        add_word(CMD_PUSH, 2'd3, D_M1, D_M1, D_M1, 32'd0);     // -3/4 rounds to zero
        add_word(CMD_PUSH, 2'd3, D_MIN, D_MIN, D_MIN, D_MIN);
        add_word(CMD_PUSH, 2'd3, D_MAX, D_MAX, D_MAX, D_MAX);
        add_word(CMD_PUSH, 2'd0, 32'h0005_0000, $urandom, $urandom, $urandom);
        add_word(CMD_PUSH, 2'd0, 32'h0005_0000, $urandom, $urandom, $urandom); // tie
        add_word(CMD_PUSH, 2'd1, 32'd2, 32'd3, $urandom, $urandom);
        add_flush();

        // directed: nearest first, ties again
        wait_idle();
        set_order(1'b1);
        add_word(CMD_PUSH, 2'd0, 32'h0007_0000, $urandom, $urandom, $urandom);
        add_word(CMD_PUSH, 2'd0, 32'hFFF9_0000, $urandom, $urandom, $urandom);
        add_word(CMD_PUSH, 2'd0, 32'h0007_0000, $urandom, $urandom, $urandom);
        add_word(CMD_PUSH, 2'd2, D_MIN, D_MAX, D_M1, $urandom);
        add_flush();

        // random: push runs closed by a flush; one run overfills the queue
        while (random_items < RANDOM_ITEMS)
        begin
            if (group == 1)
            begin
                wait_idle();
                set_order(1'b0);
            end
            else if (group != 0 && $urandom_range(0, 2) == 0)
            begin
                wait_idle();
                set_order($urandom_range(0, 1));
            end
            if (group == 3)
                n = QUEUE_DEPTH + 3;
            else if ($urandom_range(0, 9) == 0)
                n = $urandom_range(13, 40);
            else
                n = $urandom_range(0, 10);
            repeat (n) add_random_push();
            add_flush();
            random_items += n + 1;
            group++;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d pushes stored, %0d refused on a full queue, %0d flushes (%0d empty)",
                 pushes_taken, pushes_full, flushes, empty_flush);
        $display("%0d sorted words, %0d words checked, %0d order-bit writes",
                 sorted_words, words_seen, order_writes);
        if (results_due.size() != 0)
            $display("%0t: %0d expected words never arrived", $time, results_due.size());
        if (mismatches == 0 && results_due.size() == 0)
            $display("primitive_depth_sort_queue_tb passed");
        else
            $display("primitive_depth_sort_queue_tb failed");
        $finish;
    end

endmodule

### sim.f
rtl/core/pdsq_pkg.sv
rtl/core/pdsq_ram.sv
rtl/core/pdsq_avg.sv
rtl/core/pdsq_cell.sv
rtl/core/primitive_depth_sort_queue.sv
tb/primitive_depth_sort_queue_tb.sv
